// ===== rtl/lstat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lstat_pkg;

    // Fixed widths of the time path and of the serial divider
    localparam int unsigned TIME_WIDTH = 32;
    localparam int unsigned QUO_WIDTH  = 32;
    localparam int unsigned STEP_WIDTH = 6;

    // Histogram bin indexes
    localparam logic [1:0] BIN_FAST      = 2'd0;
    localparam logic [1:0] BIN_MEDIUM    = 2'd1;
    localparam logic [1:0] BIN_SLOW      = 2'd2;
    localparam logic [1:0] BIN_VERY_SLOW = 2'd3;

    // Divider command: start strobe and number of quotient bits
    typedef struct packed {
        logic                  start;
        logic [STEP_WIDTH-1:0] steps;
    } div_ctl_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Time group control
    typedef struct packed {
        logic record;
        logic clear;
    } hist_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lstat_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module lstat_div
    import lstat_pkg::*;
#(
    parameter int unsigned DIV_WIDTH = 33
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire div_ctl_t             ctl,
    input  wire logic [DIV_WIDTH-1:0] rem_init,
    input  wire logic [QUO_WIDTH-1:0] dividend,
    input  wire logic [DIV_WIDTH-1:0] divisor,
    output logic      [QUO_WIDTH-1:0] quotient,
    output logic                      rem_nonzero,
    output div_sts_t                  sts
);

    logic [STEP_WIDTH-1:0] cnt_reg;
    logic                  done_reg;
    logic [DIV_WIDTH-1:0]  rem_reg;
    logic [DIV_WIDTH-1:0]  rem_next;
    logic [DIV_WIDTH-1:0]  dsr_reg;
    logic [QUO_WIDTH-1:0]  dvd_reg;
    logic [QUO_WIDTH-1:0]  quo_reg;
    logic [DIV_WIDTH:0]    trial;
    logic                  fits;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[QUO_WIDTH-1]};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? DIV_WIDTH'(trial - {1'b0, dsr_reg}) : trial[DIV_WIDTH-1:0];
    end

    // Step counter and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            cnt_reg  <= ctl.steps;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_WIDTH'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= rem_init;
            dsr_reg <= divisor;
            dvd_reg <= dividend;
            quo_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[QUO_WIDTH-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_WIDTH-2:0], fits};
        end
    end

    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);
    assign sts.busy    = (cnt_reg != '0);
    assign sts.done    = done_reg;

endmodule

`default_nettype wire

// ===== rtl/lstat_hist.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Time group: longest, shortest and four-bin latency histogram.
module lstat_hist
    import lstat_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 32
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire hist_ctl_t                   ctl,
    input  wire logic [TIME_WIDTH-1:0]       elapsed,
    input  wire logic [TIME_WIDTH-1:0]       limit_first,
    input  wire logic [TIME_WIDTH-1:0]       limit_second,
    input  wire logic [TIME_WIDTH-1:0]       limit_third,
    output logic      [TIME_WIDTH-1:0]       longest,
    output logic      [TIME_WIDTH-1:0]       shortest,
    output logic      [3:0][COUNT_WIDTH-1:0] bin_totals
);

    logic [TIME_WIDTH-1:0]       max_reg;
    logic [TIME_WIDTH-1:0]       min_reg;
    logic                        seen_reg;
    logic [3:0][COUNT_WIDTH-1:0] bin_reg;
    logic [1:0]                  bin_sel;

    // Bin classification
    always_comb
    begin
        if (elapsed < limit_first)
        begin
            bin_sel = BIN_FAST;
        end
        else if (elapsed < limit_second)
        begin
            bin_sel = BIN_MEDIUM;
        end
        else if (elapsed < limit_third)
        begin
            bin_sel = BIN_SLOW;
        end
        else
        begin
            bin_sel = BIN_VERY_SLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg  <= '0;
            min_reg  <= '0;
            seen_reg <= 1'b0;
            bin_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            max_reg  <= '0;
            min_reg  <= '0;
            seen_reg <= 1'b0;
            bin_reg  <= '0;
        end
        else if (ctl.record)
        begin
            // first success after a clear seeds both extremes
            if (!seen_reg)
            begin
                max_reg  <= elapsed;
                min_reg  <= elapsed;
                seen_reg <= 1'b1;
            end
            else
            begin
                if (elapsed > max_reg)
                begin
                    max_reg <= elapsed;
                end
                if (elapsed < min_reg)
                begin
                    min_reg <= elapsed;
                end
            end
            bin_reg[bin_sel] <= bin_reg[bin_sel] + 1'b1;
        end
    end

    assign longest    = max_reg;
    assign shortest   = min_reg;
    assign bin_totals = bin_reg;

endmodule

`default_nettype wire

// ===== rtl/latency_outcome_statistics_core.sv =====
// A report word is registered in the cycle after its request is accepted.
// A record of a failure updates the success ratio, a success the ratio and then the
// running mean: one serial divider is shared by the ratio (one bit per cycle) and
// the running mean (32 bits, one per cycle).
// One request is in work at a time; a held report word blocks new requests.
// Reset (rst_n, async, active low) zeros all statistics and loads limits 500/1000/2000.
`timescale 1ns / 1ps
`default_nettype none

module latency_outcome_statistics_core
    import lstat_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH     = 32,
    parameter int unsigned RATIO_FRAC_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // request channel
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic        succeeded,
    input  wire logic [31:0] elapsed_ms,
    // report channel
    output logic             rpt_valid,
    input  wire logic        rpt_ready,
    output logic             report_kind,
    output logic [31:0]      success_total,
    output logic [31:0]      failure_total,
    output logic [16:0]      success_ratio,
    output logic [31:0]      longest_ms,
    output logic [31:0]      shortest_ms,
    output logic [31:0]      mean_ms,
    output logic [31:0]      bin_fast,
    output logic [31:0]      bin_medium,
    output logic [31:0]      bin_slow,
    output logic [31:0]      bin_very_slow
);

    localparam int unsigned DIV_WIDTH  = COUNT_WIDTH + 1;
    localparam int unsigned RATIO_W    = RATIO_FRAC_BITS + 1;
    localparam bit          HALVE      = (COUNT_WIDTH >= 64);
    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_COUNTS = 2'd1;
    localparam logic [1:0] REQ_TIMES  = 2'd2;

    localparam logic [1:0] CFG_LIMIT_FIRST  = 2'd0;
    localparam logic [1:0] CFG_LIMIT_SECOND = 2'd1;
    localparam logic [1:0] CFG_LIMIT_THIRD  = 2'd2;

    localparam logic [TIME_WIDTH-1:0] LIMIT_FIRST_RST  = 32'd500;
    localparam logic [TIME_WIDTH-1:0] LIMIT_SECOND_RST = 32'd1000;
    localparam logic [TIME_WIDTH-1:0] LIMIT_THIRD_RST  = 32'd2000;

    typedef enum logic [4:0] {
        S_IDLE       = 5'b00001,
        S_RATIO_GO   = 5'b00010,
        S_RATIO_WAIT = 5'b00100,
        S_MEAN_GO    = 5'b01000,
        S_MEAN_WAIT  = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;

    logic [TIME_WIDTH-1:0]  limit_first_reg;
    logic [TIME_WIDTH-1:0]  limit_second_reg;
    logic [TIME_WIDTH-1:0]  limit_third_reg;

    logic [COUNT_WIDTH-1:0] succ_cnt_reg;
    logic [COUNT_WIDTH-1:0] fail_count_reg;
    logic [RATIO_W-1:0]     ratio_reg;
    logic [TIME_WIDTH-1:0]  mean_reg;

    logic                   succ_reg;
    logic [TIME_WIDTH-1:0]  elapsed_reg;
    logic                   up_reg;

    logic                   out_valid_reg;
    logic                   kind_reg;
    logic [31:0]            succ_out_reg;
    logic [31:0]            fail_out_reg;
    logic [16:0]            ratio_out_reg;
    logic [31:0]            long_out_reg;
    logic [31:0]            short_out_reg;
    logic [31:0]            mean_out_reg;
    logic [3:0][31:0]       bin_out_reg;

    logic                   accept;
    logic                   do_record;
    logic                   do_counts;
    logic                   do_times;

    logic [COUNT_WIDTH:0]   sum_full;
    logic [COUNT_WIDTH-1:0] s_eff;
    logic [COUNT_WIDTH-1:0] f_eff;
    logic [DIV_WIDTH-1:0]   t_eff;
    logic                   ratio_zero;
    logic                   ratio_full;
    logic                   mean_up;
    logic [TIME_WIDTH-1:0]  mean_diff;

    div_ctl_t               div_ctl;
    div_sts_t               div_sts;
    logic [DIV_WIDTH-1:0]   div_rem_init;
    logic [QUO_WIDTH-1:0]   div_dividend;
    logic [DIV_WIDTH-1:0]   div_divisor;
    logic [QUO_WIDTH-1:0]   div_quotient;
    logic                   div_rem_nz;

    hist_ctl_t                   hist_ctl;
    logic [TIME_WIDTH-1:0]       hist_longest;
    logic [TIME_WIDTH-1:0]       hist_shortest;
    logic [3:0][COUNT_WIDTH-1:0] hist_bins;

    // Handshake and request decode
    assign req_ready = (state_reg == S_IDLE) && (!out_valid_reg || rpt_ready);
    assign accept    = req_valid && req_ready;
    assign do_record = accept && (req_type == REQ_RECORD);
    assign do_counts = accept && (req_type == REQ_COUNTS);
    assign do_times  = accept && (req_type == REQ_TIMES);

    // Ratio operands; counters halved only if COUNT_WIDTH >= 64 and their sum overflows
    always_comb
    begin
        sum_full = {1'b0, succ_cnt_reg} + {1'b0, fail_count_reg};
        s_eff    = succ_cnt_reg;
        f_eff    = fail_count_reg;
        t_eff    = sum_full;
        if (HALVE && sum_full[COUNT_WIDTH])
        begin
            s_eff = succ_cnt_reg >> 1;
            f_eff = fail_count_reg >> 1;
            t_eff = {1'b0, s_eff} + {1'b0, f_eff};
        end
        ratio_zero = (succ_cnt_reg == '0) && (fail_count_reg == '0);
        ratio_full = (f_eff == '0);
    end

    // Mean correction magnitude and direction
    always_comb
    begin
        mean_up   = (elapsed_reg >= mean_reg);
        mean_diff = mean_up ? (elapsed_reg - mean_reg) : (mean_reg - elapsed_reg);
    end

    // Divider command
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.steps = STEP_WIDTH'(QUO_WIDTH);
        div_rem_init  = '0;
        div_dividend  = mean_diff;
        div_divisor   = {1'b0, succ_cnt_reg};
        if (state_reg == S_RATIO_GO)
        begin
            div_ctl.start = !ratio_zero && !ratio_full;
            div_ctl.steps = STEP_WIDTH'(RATIO_FRAC_BITS);
            div_rem_init  = {1'b0, s_eff};
            div_dividend  = '0;
            div_divisor   = t_eff;
        end
        else if (state_reg == S_MEAN_GO)
        begin
            div_ctl.start = (succ_cnt_reg != '0);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (do_record)
                begin
                    state_next = S_RATIO_GO;
                end
            end
            S_RATIO_GO:
            begin
                if (div_ctl.start)
                begin
                    state_next = S_RATIO_WAIT;
                end
                else
                begin
                    state_next = succ_reg ? S_MEAN_GO : S_IDLE;
                end
            end
            S_RATIO_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = succ_reg ? S_MEAN_GO : S_IDLE;
                end
            end
            S_MEAN_GO:
            begin
                state_next = div_ctl.start ? S_MEAN_WAIT : S_IDLE;
            end
            S_MEAN_WAIT:
            begin
                if (div_sts.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Time group store
    assign hist_ctl.record = do_record && succeeded;
    assign hist_ctl.clear  = do_times;

    lstat_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (hist_ctl),
        .elapsed      (elapsed_ms),
        .limit_first  (limit_first_reg),
        .limit_second (limit_second_reg),
        .limit_third  (limit_third_reg),
        .longest      (hist_longest),
        .shortest     (hist_shortest),
        .bin_totals   (hist_bins)
    );

    lstat_div #(
        .DIV_WIDTH (DIV_WIDTH)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (div_ctl),
        .rem_init    (div_rem_init),
        .dividend    (div_dividend),
        .divisor     (div_divisor),
        .quotient    (div_quotient),
        .rem_nonzero (div_rem_nz),
        .sts         (div_sts)
    );

    // Control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_first_reg  <= LIMIT_FIRST_RST;
            limit_second_reg <= LIMIT_SECOND_RST;
            limit_third_reg  <= LIMIT_THIRD_RST;
            succ_cnt_reg     <= '0;
            fail_count_reg   <= '0;
            ratio_reg        <= '0;
            mean_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes; unused index ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT_FIRST:  limit_first_reg  <= cfg_data;
                    CFG_LIMIT_SECOND: limit_second_reg <= cfg_data;
                    CFG_LIMIT_THIRD:  limit_third_reg  <= cfg_data;
                    default:          ;
                endcase
            end

            // count group
            if (do_record)
            begin
                if (succeeded)
                begin
                    succ_cnt_reg <= succ_cnt_reg + 1'b1;
                end
                else
                begin
                    fail_count_reg <= fail_count_reg + 1'b1;
                end
            end
            else if (do_counts)
            begin
                succ_cnt_reg   <= '0;
                fail_count_reg <= '0;
            end

            // ratio
            if (do_counts)
            begin
                ratio_reg <= '0;
            end
            else if (state_reg == S_RATIO_GO)
            begin
                if (ratio_zero)
                begin
                    ratio_reg <= '0;
                end
                else if (ratio_full)
                begin
                    ratio_reg <= RATIO_ONE;
                end
            end
            else if (state_reg == S_RATIO_WAIT && div_sts.done)
            begin
                ratio_reg <= {1'b0, div_quotient[RATIO_FRAC_BITS-1:0]};
            end

            // running mean
            if (do_times)
            begin
                mean_reg <= '0;
            end
            else if (state_reg == S_MEAN_WAIT && div_sts.done)
            begin
                if (up_reg)
                begin
                    mean_reg <= mean_reg + div_quotient;
                end
                else
                begin
                    mean_reg <= mean_reg - div_quotient - {31'd0, div_rem_nz};
                end
            end

            // report word valid
            if (do_counts || do_times)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rpt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (do_record)
        begin
            succ_reg    <= succeeded;
            elapsed_reg <= elapsed_ms;
        end
        if (state_reg == S_MEAN_GO)
        begin
            up_reg <= mean_up;
        end
        if (do_counts)
        begin
            kind_reg      <= 1'b0;
            succ_out_reg  <= 32'(succ_cnt_reg);
            fail_out_reg  <= 32'(fail_count_reg);
            ratio_out_reg <= 17'(ratio_reg);
            long_out_reg  <= '0;
            short_out_reg <= '0;
            mean_out_reg  <= '0;
            bin_out_reg   <= '0;
        end
        else if (do_times)
        begin
            kind_reg       <= 1'b1;
            succ_out_reg   <= '0;
            fail_out_reg   <= '0;
            ratio_out_reg  <= '0;
            long_out_reg   <= hist_longest;
            short_out_reg  <= hist_shortest;
            mean_out_reg   <= mean_reg;
            bin_out_reg[BIN_FAST]      <= 32'(hist_bins[BIN_FAST]);
            bin_out_reg[BIN_MEDIUM]    <= 32'(hist_bins[BIN_MEDIUM]);
            bin_out_reg[BIN_SLOW]      <= 32'(hist_bins[BIN_SLOW]);
            bin_out_reg[BIN_VERY_SLOW] <= 32'(hist_bins[BIN_VERY_SLOW]);
        end
    end

    assign rpt_valid     = out_valid_reg;
    assign report_kind   = kind_reg;
    assign success_total = succ_out_reg;
    assign failure_total = fail_out_reg;
    assign success_ratio = ratio_out_reg;
    assign longest_ms    = long_out_reg;
    assign shortest_ms   = short_out_reg;
    assign mean_ms       = mean_out_reg;
    assign bin_fast      = bin_out_reg[BIN_FAST];
    assign bin_medium    = bin_out_reg[BIN_MEDIUM];
    assign bin_slow      = bin_out_reg[BIN_SLOW];
    assign bin_very_slow = bin_out_reg[BIN_VERY_SLOW];

`ifndef ASSERT_OFF
    // no request is taken while the divider still works on the last one
    a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> !div_sts.busy)
        else $error("request accepted while divider busy");

    // ratio never exceeds one
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(ratio_reg > RATIO_ONE))
        else $error("success ratio above one");

    // shortest time never above longest
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        !(hist_shortest > hist_longest))
        else $error("shortest time above longest");

    // a mean divider result is consumed the cycle it is flagged
    a_wait_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEAN_WAIT && div_sts.done) |=> (state_reg == S_IDLE))
        else $error("mean update did not complete");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/lstat_tb_pkg.sv =====
`timescale 1ns / 1ps

package lstat_tb_pkg;

    // Request codes on req_type
    typedef enum logic [1:0] {
        REQ_RECORD       = 2'd0,
        REQ_COUNT_REPORT = 2'd1,
        REQ_TIME_REPORT  = 2'd2,
        REQ_UNUSED       = 2'd3
    } req_code_e;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LIMIT_FIRST  = 2'd0,
        REG_LIMIT_SECOND = 2'd1,
        REG_LIMIT_THIRD  = 2'd2
    } cfg_reg_e;

    // Report kinds on report_kind
    typedef enum logic {
        KIND_COUNT = 1'b0,
        KIND_TIME  = 1'b1
    } report_kind_e;

endpackage

// ===== tb/sv/lstat_checker.sv =====
`timescale 1ns / 1ps

module lstat_checker
    import lstat_pkg::*;
    import lstat_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        req_valid,
    input  logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic        succeeded,
    input  logic [31:0] elapsed_ms,
    input  logic        rpt_valid,
    input  logic        rpt_ready,
    input  logic        report_kind,
    input  logic [31:0] success_total,
    input  logic [31:0] failure_total,
    input  logic [16:0] success_ratio,
    input  logic [31:0] longest_ms,
    input  logic [31:0] shortest_ms,
    input  logic [31:0] mean_ms,
    input  logic [31:0] bin_fast,
    input  logic [31:0] bin_medium,
    input  logic [31:0] bin_slow,
    input  logic [31:0] bin_very_slow,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic             kind;
        logic [31:0]      successes;
        logic [31:0]      failures;
        logic [16:0]      ratio;
        logic [31:0]      longest;
        logic [31:0]      shortest;
        logic [31:0]      mean;
        logic [3:0][31:0] bin_vals;
    } report_word_t;

    // Predicted statistics
    logic [31:0] limits [3];
    logic [31:0] succ_cnt;
    logic [31:0] fail_count;
    logic [16:0] ratio_q16;
    logic [31:0] longest;
    logic [31:0] shortest;
    logic [31:0] running_mean;
    logic [31:0] bin_counts [4];
    logic        any_time;

    report_word_t reports_due[$];
    report_word_t want;
    int           errs;

    // floor(s * 2^16 / (s + f)) with an exact total; zero total gives zero
    function automatic logic [16:0] ratio_of(logic [31:0] s, logic [31:0] f);
        logic [32:0] total;
        logic [63:0] scaled;
        total = {1'b0, s} + {1'b0, f};
        scaled = {16'b0, s, 16'b0};
        if (total == 33'd0)
            return 17'd0;
        return 17'(scaled / {31'b0, total});
    endfunction

    task automatic clear_counts();
        succ_cnt = '0;
        fail_count = '0;
        ratio_q16 = '0;
    endtask

    task automatic clear_times();
        longest = '0;
        shortest = '0;
        running_mean = '0;
        any_time = 1'b0;
        for (int i = 0; i < 4; i++)
            bin_counts[i] = '0;
    endtask

    // Successful operation: extremes, running mean and histogram
    task automatic record_time(logic [31:0] ms);
        logic [31:0] n;
        logic [31:0] gap;
        logic [1:0]  bin;
        n = succ_cnt;
        if (!any_time) begin
            longest = ms;
            shortest = ms;
            any_time = 1'b1;
        end
        else begin
            if (ms > longest)
                longest = ms;
            if (ms < shortest)
                shortest = ms;
        end
        // floor of the updated mean: round the downward step up
        if (n != 32'd0) begin
            if (ms >= running_mean)
                running_mean = running_mean + (ms - running_mean) / n;
            else begin
                gap = running_mean - ms;
                running_mean = running_mean
                             - 32'(({1'b0, gap} + {1'b0, n} - 33'd1) / {1'b0, n});
            end
        end
        if (ms < limits[0])
            bin = BIN_FAST;
        else if (ms < limits[1])
            bin = BIN_MEDIUM;
        else if (ms < limits[2])
            bin = BIN_SLOW;
        else
            bin = BIN_VERY_SLOW;
        bin_counts[bin] = bin_counts[bin] + 32'd1;
    endtask

    task automatic handle_request(logic [1:0] code, logic ok, logic [31:0] ms);
        report_word_t word;
        word = '0;
        case (code)
            REQ_RECORD:
            begin
                if (ok)
                    succ_cnt = succ_cnt + 32'd1;
                else
                    fail_count = fail_count + 32'd1;
                ratio_q16 = ratio_of(succ_cnt, fail_count);
                if (ok)
                    record_time(ms);
            end
            REQ_COUNT_REPORT:
            begin
                word.kind = KIND_COUNT;
                word.successes = succ_cnt;
                word.failures = fail_count;
                word.ratio = ratio_q16;
                reports_due.push_back(word);
                clear_counts();
            end
            REQ_TIME_REPORT:
            begin
                word.kind = KIND_TIME;
                word.longest = longest;
                word.shortest = shortest;
                word.mean = running_mean;
                for (int i = 0; i < 4; i++)
                    word.bin_vals[i] = bin_counts[i];
                reports_due.push_back(word);
                clear_times();
            end
            default:
            begin
                // unused code: no effect at all
            end
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limits[0] = 32'd500;
            limits[1] = 32'd1000;
            limits[2] = 32'd2000;
            clear_counts();
            clear_times();
            reports_due.delete();
            errs = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LIMIT_FIRST:  limits[0] = cfg_data;
                    REG_LIMIT_SECOND: limits[1] = cfg_data;
                    REG_LIMIT_THIRD:  limits[2] = cfg_data;
                    default:          ;
                endcase
            end

            // outgoing report word vs oldest prediction
            if (rpt_valid && rpt_ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: report word with none expected, kind %0d",
                             $time, report_kind);
                    errs++;
                end
                else begin
                    want = reports_due.pop_front();
                    check_field("report_kind", 32'(want.kind), 32'(report_kind));
                    check_field("success_total", want.successes, success_total);
                    check_field("failure_total", want.failures, failure_total);
                    check_field("success_ratio", 32'(want.ratio), 32'(success_ratio));
                    check_field("longest_ms", want.longest, longest_ms);
                    check_field("shortest_ms", want.shortest, shortest_ms);
                    check_field("mean_ms", want.mean, mean_ms);
                    check_field("bin_fast", want.bin_vals[BIN_FAST], bin_fast);
                    check_field("bin_medium", want.bin_vals[BIN_MEDIUM], bin_medium);
                    check_field("bin_slow", want.bin_vals[BIN_SLOW], bin_slow);
                    check_field("bin_very_slow", want.bin_vals[BIN_VERY_SLOW],
                                bin_very_slow);
                end
            end

            // incoming request word
            if (req_valid && req_ready)
                handle_request(req_type, succeeded, elapsed_ms);

            mismatches <= errs;
            pending <= reports_due.size();
        end
    end

endmodule

// ===== tb/sv/latency_outcome_statistics_core_tb.sv =====
`timescale 1ns / 1ps

module latency_outcome_statistics_core_tb;
    import lstat_tb_pkg::*;

    localparam int SETTLE_CYCLES = 80;      // covers a success record
    localparam int RX_LONG_HOLD  = 400;
    localparam int CYCLE_LIMIT   = 500000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic        succeeded;
    logic [31:0] elapsed_ms;
    logic        rpt_valid;
    logic        rpt_ready;
    logic        report_kind;
    logic [31:0] success_total;
    logic [31:0] failure_total;
    logic [16:0] success_ratio;
    logic [31:0] longest_ms;
    logic [31:0] shortest_ms;
    logic [31:0] mean_ms;
    logic [31:0] bin_fast;
    logic [31:0] bin_medium;
    logic [31:0] bin_slow;
    logic [31:0] bin_very_slow;
    int          mismatches;
    int          pending;

    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    bit          rx_hold_req = 1'b0;
    logic [31:0] bin_limits [3] = '{32'd500, 32'd1000, 32'd2000};

    latency_outcome_statistics_core uut (.*);

    lstat_checker u_checker (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // elapsed times aimed at the current bin edges and the field extremes
    function automatic logic [31:0] pick_ms();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            3, 4, 5: return bin_limits[$urandom_range(0, 2)] + $urandom_range(0, 4) - 32'd2;
            default: return $urandom_range(0, 2500);
        endcase
    endfunction

    // report channel: random back-pressure plus one long hold on request
    initial begin
        int len;
        rpt_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rpt_ready <= 1'b0;
                repeat (RX_LONG_HOLD) @(posedge clk);
            end
            else begin
                len = idle_gap();
                if (len > 0) begin
                    rpt_ready <= 1'b0;
                    repeat (len) @(posedge clk);
                end
                rpt_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // offer one request word and return at the edge that takes it
    task automatic send_word(req_code_e code, logic ok, logic [31:0] ms);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= code;
        succeeded <= ok;
        elapsed_ms <= ms;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // must be called in the step of the last accept
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic write_limits(logic [31:0] first, logic [31:0] second, logic [31:0] third);
        write_reg(REG_LIMIT_FIRST, first);
        write_reg(REG_LIMIT_SECOND, second);
        write_reg(REG_LIMIT_THIRD, third);
        cfg_we <= 1'b0;
        bin_limits[0] = first;
        bin_limits[1] = second;
        bin_limits[2] = third;
    endtask

    // random traffic, mostly records; unused codes do not count
    task automatic random_words(int count);
        int done;
        int r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(REQ_UNUSED, 1'($urandom()), $urandom());
            else begin
                if (r < 15)
                    send_word(REQ_COUNT_REPORT, 1'($urandom()), $urandom());
                else if (r < 27)
                    send_word(REQ_TIME_REPORT, 1'($urandom()), $urandom());
                else
                    send_word(REQ_RECORD, $urandom_range(0, 3) != 0, pick_ms());
                done++;
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_LIMIT_FIRST;
        cfg_data <= '0;
        req_valid <= 1'b0;
        req_type <= REQ_RECORD;
        succeeded <= 1'b0;
        elapsed_ms <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty reports, bin edges, extremes, unused code, re-seeding
        send_word(REQ_COUNT_REPORT, 1'b0, 32'd0);
        send_word(REQ_TIME_REPORT, 1'b0, 32'd0);
        send_word(REQ_RECORD, 1'b0, 32'hFFFF_FFFF);
        send_word(REQ_RECORD, 1'b1, 32'd0);
        send_word(REQ_RECORD, 1'b1, 32'hFFFF_FFFF);
        send_word(REQ_RECORD, 1'b1, 32'd499);
        send_word(REQ_RECORD, 1'b1, 32'd500);
        send_word(REQ_RECORD, 1'b1, 32'd999);
        send_word(REQ_RECORD, 1'b1, 32'd1000);
        send_word(REQ_RECORD, 1'b1, 32'd1999);
        send_word(REQ_RECORD, 1'b1, 32'd2000);
        send_word(REQ_RECORD, 1'b0, 32'd0);
        send_word(REQ_COUNT_REPORT, 1'b1, 32'hFFFF_FFFF);
        send_word(REQ_TIME_REPORT, 1'b1, 32'hFFFF_FFFF);
        send_word(REQ_UNUSED, 1'b1, 32'd7);
        send_word(REQ_RECORD, 1'b1, 32'd1234);
        send_word(REQ_RECORD, 1'b1, 32'd1);
        send_word(REQ_COUNT_REPORT, 1'b0, 32'd0);
        send_word(REQ_TIME_REPORT, 1'b0, 32'd0);
        send_word(REQ_COUNT_REPORT, 1'b0, 32'd0);
        wait_idle();

        // small limits; report channel held off while count reports are sent
        write_limits(32'd100, 32'd200, 32'd300);
        rx_hold_req = 1'b1;
        repeat (6)
            send_word(REQ_COUNT_REPORT, 1'b0, 32'd0);
        random_words(100);
        wait_idle();

        // all limits zero: every success lands in the last bin
        write_limits(32'd0, 32'd0, 32'd0);
        random_words(60);
        wait_idle();

        // all limits at maximum, run without idling
        write_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        random_words(60);
        no_idle = 1'b0;
        wait_idle();

        // out-of-order limits
        write_limits($urandom(), $urandom_range(0, 3000), 32'd1500);
        random_words(100);
        wait_idle();

        // back to the reset values
        write_limits(32'd500, 32'd1000, 32'd2000);
        random_words(80);
        wait_idle();

        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lstat_pkg.sv
rtl/lstat_div.sv
rtl/lstat_hist.sv
rtl/latency_outcome_statistics_core.sv
tb/sv/lstat_tb_pkg.sv
tb/sv/lstat_checker.sv
tb/sv/latency_outcome_statistics_core_tb.sv
